// ----- hw/rtl/lcdns_pkg.sv -----
`default_nettype none

package lcdns_pkg;

	// request kind codes as they arrive on the input
	localparam logic [2:0] KIND_INIT  = 3'd0;
	localparam logic [2:0] KIND_DATA  = 3'd1;
	localparam logic [2:0] KIND_CMD   = 3'd2;
	localparam logic [2:0] KIND_GOTO  = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	// work items handed from the front to the back
	typedef enum logic [2:0] {
		OP_INIT,
		OP_DATA,
		OP_CMD,
		OP_GOTO,
		OP_CLEAR
	} op_t;

	localparam logic [7:0] GAP_NONE   = 8'd0;
	localparam logic [7:0] GAP_CMD    = 8'd2;
	localparam logic [7:0] GAP_GOTO   = 8'd100;
	localparam logic [7:0] GAP_CLEAR  = 8'd200;
	localparam logic [7:0] GAP_INIT   = 8'd1;
	localparam logic [7:0] GAP_INIT_CLR = 8'd10;

	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME_ROW2 = 8'hC0;
	localparam logic [7:0] CMD_HOME_ROW1 = 8'h80;

	localparam logic [2:0] ROW_HOME = 3'd1;
	localparam logic [2:0] ROW_WRAP = 3'd2;
	localparam logic [7:0] COL_HOME = 8'd1;

	localparam logic [3:0] INIT_LAST_STEP = 4'd13;
	localparam logic [5:0] LINE_LENGTH_RESET = 6'd16;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic [2:0] target_row;
		logic [5:0] target_col;
	} req_t;

	typedef struct packed {
		logic       rs;
		logic [3:0] nibble;
		logic [7:0] gap_ms;
		logic [2:0] cursor_row;
		logic [7:0] cursor_col;
		logic       last;
	} rsp_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] cmd_byte;
		logic       wrap;
		logic [2:0] row0;
		logic [7:0] col0;
		logic [2:0] row1;
		logic [7:0] col1;
	} job_t;

	function automatic logic [7:0] row_base(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'h80;
			2'd1: b = 8'hC0;
			2'd2: b = 8'h94;
			2'd3: b = 8'hD4;
			default: b = 8'h80;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h33;
			3'd1: c = 8'h32;
			3'd2: c = 8'h28;
			3'd3: c = 8'h0E;
			3'd4: c = 8'h01;
			3'd5: c = 8'h06;
			3'd6: c = 8'h0C;
			default: c = 8'h0C;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lcdns_front.sv -----
`default_nettype none

module lcdns_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lcdns_pkg::req_t req,
	input  wire logic            q_full,
	input  wire logic            cfg_we,
	input  wire logic [5:0]      cfg_data,
	output logic                 q_push,
	output lcdns_pkg::job_t      q_job
);

	logic [5:0] line_length_q;
	logic [2:0] cur_row_q;
	logic [7:0] cur_col_q;
	logic       known;
	logic       accept;
	logic [7:0] col_inc;
	logic [7:0] goto_addr;
	logic [2:0] new_row;
	logic [7:0] new_col;

	assign col_inc   = cur_col_q + 8'd1;
	assign goto_addr = lcdns_pkg::row_base(req.target_row[1:0] - 2'd1)
		+ {2'b00, req.target_col} - 8'd1;

	always_comb begin
		q_job.op       = lcdns_pkg::OP_INIT;
		q_job.cmd_byte = req.value;
		q_job.wrap     = 1'b0;
		q_job.row0     = cur_row_q;
		q_job.col0     = cur_col_q;
		q_job.row1     = cur_row_q;
		q_job.col1     = cur_col_q;
		new_row        = cur_row_q;
		new_col        = cur_col_q;
		known          = 1'b1;
		unique case (req.kind)
			lcdns_pkg::KIND_INIT: begin
				q_job.op = lcdns_pkg::OP_INIT;
				new_row  = lcdns_pkg::ROW_HOME;
				new_col  = lcdns_pkg::COL_HOME;
			end
			lcdns_pkg::KIND_DATA: begin
				q_job.op   = lcdns_pkg::OP_DATA;
				q_job.col1 = col_inc;
				q_job.wrap = (col_inc == ({2'b00, line_length_q} + 8'd1));
				if (q_job.wrap) begin
					new_row = lcdns_pkg::ROW_WRAP;
					new_col = lcdns_pkg::COL_HOME;
				end else begin
					new_col = col_inc;
				end
			end
			lcdns_pkg::KIND_CMD: begin
				q_job.op = lcdns_pkg::OP_CMD;
			end
			lcdns_pkg::KIND_GOTO: begin
				q_job.op       = lcdns_pkg::OP_GOTO;
				q_job.cmd_byte = goto_addr;
				q_job.row1     = req.target_row;
				q_job.col1     = {2'b00, req.target_col};
				new_row        = req.target_row;
				new_col        = {2'b00, req.target_col};
			end
			lcdns_pkg::KIND_CLEAR: begin
				q_job.op = lcdns_pkg::OP_CLEAR;
				new_row  = lcdns_pkg::ROW_HOME;
				new_col  = lcdns_pkg::COL_HOME;
			end
			default: known = 1'b0;
		endcase
	end

	assign accept = push && !q_full;
	assign q_push = accept && known;

	// cursor is tracked here, in request order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= lcdns_pkg::LINE_LENGTH_RESET;
			cur_row_q     <= lcdns_pkg::ROW_HOME;
			cur_col_q     <= lcdns_pkg::COL_HOME;
		end else begin
			if (cfg_we) begin
				line_length_q <= cfg_data;
			end
			if (q_push) begin
				cur_row_q <= new_row;
				cur_col_q <= new_col;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lcdns_queue.sv -----
`default_nettype none

module lcdns_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire lcdns_pkg::job_t wdata,
	output logic                 full,
	input  wire logic            rd,
	output lcdns_pkg::job_t      rdata,
	output logic                 empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	lcdns_pkg::job_t mem [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST_IDX) ? '0 : rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lcdns_back.sv -----
`default_nettype none

module lcdns_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lcdns_pkg::job_t q_job,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output lcdns_pkg::rsp_t      rsp,
	output logic                 empty,
	input  wire logic            pop
);

	lcdns_pkg::job_t job_q;
	logic            busy_q;
	logic [3:0]      step_q;
	lcdns_pkg::rsp_t rsp_q;
	logic            out_valid_q;
	lcdns_pkg::rsp_t strobe;
	logic            advance;
	logic            job_load;

	// one strobe of the current job at the current step
	always_comb begin
		logic [7:0] icmd;
		icmd          = lcdns_pkg::init_cmd(step_q[3:1]);
		strobe.rs         = 1'b0;
		strobe.nibble     = step_q[0] ? job_q.cmd_byte[3:0] : job_q.cmd_byte[7:4];
		strobe.gap_ms     = lcdns_pkg::GAP_CMD;
		strobe.cursor_row = (step_q == 4'd0) ? job_q.row0 : job_q.row1;
		strobe.cursor_col = (step_q == 4'd0) ? job_q.col0 : job_q.col1;
		strobe.last       = (step_q == 4'd1);
		unique case (job_q.op)
			lcdns_pkg::OP_INIT: begin
				strobe.nibble     = step_q[0] ? icmd[3:0] : icmd[7:4];
				strobe.cursor_row = lcdns_pkg::ROW_HOME;
				strobe.cursor_col = lcdns_pkg::COL_HOME;
				strobe.last       = (step_q == lcdns_pkg::INIT_LAST_STEP);
				if (step_q[0]) begin
					strobe.gap_ms = (icmd == lcdns_pkg::CMD_CLEAR) ?
						lcdns_pkg::GAP_INIT_CLR : lcdns_pkg::GAP_INIT;
				end
			end
			lcdns_pkg::OP_DATA: begin
				strobe.rs     = (step_q[3:1] == 3'd0);
				strobe.gap_ms = lcdns_pkg::GAP_NONE;
				strobe.last   = job_q.wrap ? (step_q == 4'd3) : (step_q == 4'd1);
				if (step_q[3:1] != 3'd0) begin
					strobe.nibble = step_q[0] ? lcdns_pkg::CMD_HOME_ROW2[3:0] :
						lcdns_pkg::CMD_HOME_ROW2[7:4];
					strobe.gap_ms     = step_q[0] ? lcdns_pkg::GAP_GOTO : lcdns_pkg::GAP_CMD;
					strobe.cursor_row = lcdns_pkg::ROW_WRAP;
					strobe.cursor_col = lcdns_pkg::COL_HOME;
				end
			end
			lcdns_pkg::OP_CMD: begin
				strobe.gap_ms = step_q[0] ? lcdns_pkg::GAP_NONE : lcdns_pkg::GAP_CMD;
			end
			lcdns_pkg::OP_GOTO: begin
				strobe.gap_ms = step_q[0] ? lcdns_pkg::GAP_GOTO : lcdns_pkg::GAP_CMD;
			end
			lcdns_pkg::OP_CLEAR: begin
				strobe.last = (step_q == 4'd3);
				if (step_q != 4'd0) begin
					strobe.cursor_row = lcdns_pkg::ROW_HOME;
					strobe.cursor_col = lcdns_pkg::COL_HOME;
				end
				if (step_q[1]) begin
					strobe.nibble = step_q[0] ? lcdns_pkg::CMD_HOME_ROW1[3:0] :
						lcdns_pkg::CMD_HOME_ROW1[7:4];
					strobe.gap_ms = step_q[0] ? lcdns_pkg::GAP_GOTO : lcdns_pkg::GAP_CMD;
				end else begin
					strobe.nibble = step_q[0] ? lcdns_pkg::CMD_CLEAR[3:0] :
						lcdns_pkg::CMD_CLEAR[7:4];
					strobe.gap_ms = step_q[0] ? lcdns_pkg::GAP_CLEAR : lcdns_pkg::GAP_CMD;
				end
			end
			default: ;
		endcase
	end

	assign advance  = busy_q && (!out_valid_q || pop);
	assign job_load = !q_empty && (!busy_q || (advance && strobe.last));
	assign q_pop    = job_load;
	assign rsp      = rsp_q;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q <= q_job;
		end
		if (advance) begin
			rsp_q <= strobe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (job_load) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (advance) begin
				if (strobe.last) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 4'd1;
			end
		end
	end

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= lcdns_pkg::INIT_LAST_STEP)
		else $error("sequencer step beyond longest job");

	a_load_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		job_load |-> !q_empty)
		else $error("job taken from empty queue");

	a_no_load_midjob: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !(advance && strobe.last)) |-> !job_load)
		else $error("new job loaded before current one finished");

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		job_load |=> (busy_q && step_q == 4'd0))
		else $error("loaded job does not start at first strobe");

endmodule

`default_nettype wire

// ----- hw/rtl/char_lcd_nibble_sequencer.sv -----
`default_nettype none

// Character LCD sequencer for a 4-bit bus. Each request (init, data character,
// raw command, goto, clear) becomes a run of enable-strobe transactions on the
// result side, high nibble first, each with its register-select level, nibble,
// pause in ms and the tracked cursor; the final one carries last. A request
// is taken whenever the request queue has room; the sequencer then gives one
// strobe per cycle while the result side keeps popping. An init request gives
// 14 strobes, a clear 4, a goto or raw command 2, and a data character 2, or 4
// when it wraps to row two. The strobe sequencer steps through one strobe a
// cycle into the output register while that register is free or popped.
// Unknown kinds are accepted and dropped. line_length is written on the cfg
// channel, which is always ready; write it only while idle.
module char_lcd_nibble_sequencer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// request side
	input  wire logic            push,
	output logic                 full,
	input  wire lcdns_pkg::req_t req,
	// strobe side
	output logic                 empty,
	input  wire logic            pop,
	output lcdns_pkg::rsp_t      rsp,
	// line_length register
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [5:0]      cfg_data
);

	lcdns_pkg::job_t in_job;
	lcdns_pkg::job_t head_job;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	// front: classifies, tracks the cursor and works out goto addresses
	lcdns_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.req      (req),
		.q_full   (q_full),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.q_push   (q_push),
		.q_job    (in_job)
	);

	// short queue so the front keeps taking requests while strobes drain
	lcdns_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (in_job),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (head_job),
		.empty  (q_empty)
	);

	// back: steps each job out as strobes, one per cycle while the strobe side keeps popping
	lcdns_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_job   (head_job),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.rsp     (rsp),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

`default_nettype wire

// ----- bench/char_lcd_strobe_checker.sv -----
`timescale 1ns / 100ps

// watches both queue sides and the line_length write channel, predicts the
// strobe transactions each accepted request should give and compares them
module char_lcd_strobe_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire logic            full,
	input  wire lcdns_pkg::req_t req,
	input  wire logic            empty,
	input  wire logic            pop,
	input  wire lcdns_pkg::rsp_t rsp,
	input  wire logic            cfg_valid,
	input  wire logic            cfg_ready,
	input  wire logic [5:0]      cfg_data,
	output int                   errors,
	output int                   outstanding,
	output int                   requests,
	output int                   strobes,
	output int                   wraps
);

	// goto base address per row, row 1 in the low byte
	localparam logic [31:0] ROW_ADDRS  = {8'hD4, 8'h94, 8'hC0, 8'h80};
	// power-up command bytes, first one in the low byte
	localparam logic [55:0] INIT_BYTES = {8'h0C, 8'h06, 8'h01, 8'h0E, 8'h28, 8'h32, 8'h33};
	localparam int          INIT_CLEAR_STEP = 4;

	lcdns_pkg::rsp_t pending_strobes[$];
	logic [5:0]      line_len;
	logic [7:0]      cur_col;
	logic [2:0]      cur_row;
	int              err_total;
	int              req_total;
	int              strobe_total;
	int              wrap_total;

	function automatic void add_strobe(input logic sel, input logic [3:0] nib,
		input logic [7:0] gap);
		lcdns_pkg::rsp_t s;
		s.rs         = sel;
		s.nibble     = nib;
		s.gap_ms     = gap;
		s.cursor_row = cur_row;
		s.cursor_col = cur_col;
		s.last       = 1'b0;
		pending_strobes.push_back(s);
	endfunction

	// cursor moves between the two nibbles
	function automatic void send_command(input logic [7:0] cmd, input logic [7:0] settle,
		input logic [2:0] row, input logic [7:0] col);
		add_strobe(1'b0, cmd[7:4], lcdns_pkg::GAP_CMD);
		cur_row = row;
		cur_col = col;
		add_strobe(1'b0, cmd[3:0], settle);
	endfunction

	function automatic void send_goto(input logic [2:0] row, input logic [7:0] col);
		logic [2:0] row_off;
		logic [7:0] addr;
		row_off = row - 3'd1;
		addr    = ROW_ADDRS[{row_off[1:0], 3'b000} +: 8] + col - 8'd1;
		send_command(addr, lcdns_pkg::GAP_GOTO, row, col);
	endfunction

	function automatic void predict_request(input lcdns_pkg::req_t r);
		int              before_n;
		lcdns_pkg::rsp_t tail;
		before_n = pending_strobes.size();
		case (r.kind)
			lcdns_pkg::KIND_INIT: begin
				cur_row = lcdns_pkg::ROW_HOME;
				cur_col = lcdns_pkg::COL_HOME;
				for (int i = 0; i < 7; i++)
					send_command(INIT_BYTES[i*8 +: 8],
						(i == INIT_CLEAR_STEP) ? lcdns_pkg::GAP_INIT_CLR : lcdns_pkg::GAP_INIT,
						lcdns_pkg::ROW_HOME, lcdns_pkg::COL_HOME);
			end
			lcdns_pkg::KIND_DATA: begin
				add_strobe(1'b1, r.value[7:4], lcdns_pkg::GAP_NONE);
				cur_col = cur_col + 8'd1;
				add_strobe(1'b1, r.value[3:0], lcdns_pkg::GAP_NONE);
				if (cur_col == ({2'b00, line_len} + 8'd1)) begin
					wrap_total++;
					cur_col = lcdns_pkg::COL_HOME;
					cur_row = lcdns_pkg::ROW_WRAP;
					send_goto(lcdns_pkg::ROW_WRAP, lcdns_pkg::COL_HOME);
				end
			end
			lcdns_pkg::KIND_CMD:
				send_command(r.value, lcdns_pkg::GAP_NONE, cur_row, cur_col);
			lcdns_pkg::KIND_GOTO:
				send_goto(r.target_row, {2'b00, r.target_col});
			lcdns_pkg::KIND_CLEAR: begin
				send_command(lcdns_pkg::CMD_CLEAR, lcdns_pkg::GAP_CLEAR,
					lcdns_pkg::ROW_HOME, lcdns_pkg::COL_HOME);
				send_goto(lcdns_pkg::ROW_HOME, lcdns_pkg::COL_HOME);
			end
			default: ;
		endcase
		if (pending_strobes.size() > before_n) begin
			tail      = pending_strobes.pop_back();
			tail.last = 1'b1;
			pending_strobes.push_back(tail);
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			err_total++;
			$display("%0t ns: strobe %0d %s expected 0x%0h actual 0x%0h",
				$time, strobe_total, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lcdns_pkg::rsp_t want;
		if (!arst_n) begin
			line_len = lcdns_pkg::LINE_LENGTH_RESET;
			cur_col  = lcdns_pkg::COL_HOME;
			cur_row  = lcdns_pkg::ROW_HOME;
			pending_strobes.delete();
		end else begin
			if (pop && !empty) begin
				if (pending_strobes.size() == 0) begin
					err_total++;
					$display("%0t ns: unexpected strobe expected none actual 0x%0h",
						$time, rsp);
				end else begin
					want = pending_strobes.pop_front();
					check_field("rs", want.rs, rsp.rs);
					check_field("nibble", want.nibble, rsp.nibble);
					check_field("gap_ms", want.gap_ms, rsp.gap_ms);
					check_field("cursor_row", want.cursor_row, rsp.cursor_row);
					check_field("cursor_col", want.cursor_col, rsp.cursor_col);
					check_field("last", want.last, rsp.last);
				end
				strobe_total++;
			end
			if (push && !full) begin
				req_total++;
				predict_request(req);
			end
			if (cfg_valid && cfg_ready)
				line_len = cfg_data;
		end
		errors      <= err_total;
		outstanding <= pending_strobes.size();
		requests    <= req_total;
		strobes     <= strobe_total;
		wraps       <= wrap_total;
	end

endmodule

// ----- bench/char_lcd_nibble_sequencer_tb.sv -----
`timescale 1ns / 100ps

// stimulus and verdict; all prediction and comparison lives in the checker
module char_lcd_nibble_sequencer_tb;

	// kinds the block must swallow without any strobe
	localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
	localparam logic [2:0] KIND_SPARE_MID = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI  = 3'd7;
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int SETTLE_CYCLES = 20;  // covers a dropped request still in flight
	localparam int QUIET_LIMIT  = 2000; // cycles with no transaction at all

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            push      = 1'b0;
	lcdns_pkg::req_t req       = '0;
	logic            pop       = 1'b0;
	logic            cfg_valid = 1'b0;
	logic [5:0]      cfg_data  = '0;
	logic            cfg_ready;
	logic            full;
	logic            empty;
	lcdns_pkg::rsp_t rsp;

	int errors;
	int outstanding;
	int requests;
	int strobes;
	int wraps;

	// idling knobs, written by the stimulus process only
	int   tx_idle_pct  = 0;
	int   rx_stall_pct = 0;
	logic hold_now     = 1'b0;
	// written by the receiver process only
	logic hold_done    = 1'b0;
	// shadow of line_length, only used to aim gotos at the end of a line
	logic [5:0] line_len = lcdns_pkg::LINE_LENGTH_RESET;
	int quiet_cycles = 0;

	char_lcd_nibble_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.empty    (empty),
		.pop      (pop),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	char_lcd_strobe_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req        (req),
		.empty      (empty),
		.pop        (pop),
		.rsp        (rsp),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.outstanding(outstanding),
		.requests   (requests),
		.strobes    (strobes),
		.wraps      (wraps)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off counted here so that
	// the request queue fills up and full pushes back on the sender
	initial begin
		forever begin
			@(posedge clk);
			if (hold_now && !hold_done) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// watchdog: a hung block shows up as a long run with no transaction
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d strobes still due",
				QUIET_LIMIT, outstanding);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// push stays high between back-to-back requests, dropped only for idle gaps and when draining
	task automatic send_request(input lcdns_pkg::req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req  <= r;
		do @(posedge clk); while (full);
	endtask

	function automatic lcdns_pkg::req_t make_request(input logic [2:0] kind,
		input logic [7:0] value, input logic [2:0] row, input logic [5:0] col);
		lcdns_pkg::req_t r;
		r.kind       = kind;
		r.value      = value;
		r.target_row = row;
		r.target_col = col;
		return r;
	endfunction

	// mostly well-formed traffic: plenty of characters, gotos aimed at the
	// line end so the next character wraps, and a little out-of-range noise
	function automatic lcdns_pkg::req_t random_request();
		lcdns_pkg::req_t r;
		int              pick;
		r = make_request(3'($urandom_range(7)), 8'($urandom_range(255)),
			3'($urandom_range(7)), 6'($urandom_range(63)));
		pick = $urandom_range(99);
		if (pick < 45) begin
			r.kind = lcdns_pkg::KIND_DATA;
		end else if (pick < 62) begin
			r.kind = lcdns_pkg::KIND_GOTO;
			if ($urandom_range(4) != 0) begin
				r.target_row = 3'($urandom_range(4, 1));
				r.target_col = $urandom_range(1) ? line_len : 6'($urandom_range(40, 1));
			end
		end else if (pick < 77) begin
			r.kind = lcdns_pkg::KIND_CMD;
		end else if (pick < 85) begin
			r.kind = lcdns_pkg::KIND_CLEAR;
		end else if (pick < 91) begin
			r.kind = lcdns_pkg::KIND_INIT;
		end else begin
			r.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
		end
		return r;
	endfunction

	// wait until every predicted strobe has been popped, then let a dropped
	// request clear the pipeline
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_line_length(input logic [5:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		line_len = len;
	endtask

	task automatic run_phase(input logic [5:0] len, input int tx_pct, input int rx_pct,
		input int count);
		drain();
		write_line_length(len);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (count) send_request(random_request());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset line length of 16, no idling
		send_request(make_request(lcdns_pkg::KIND_INIT, 8'h00, 3'd0, 6'd0));
		send_request(make_request(lcdns_pkg::KIND_DATA, 8'h00, 3'd7, 6'd63));
		send_request(make_request(lcdns_pkg::KIND_DATA, 8'hFF, 3'd0, 6'd0));
		send_request(make_request(lcdns_pkg::KIND_CMD, 8'h00, 3'd7, 6'd63));
		send_request(make_request(lcdns_pkg::KIND_CMD, 8'hFF, 3'd0, 6'd0));
		send_request(make_request(lcdns_pkg::KIND_GOTO, 8'h00, 3'd1, 6'd1));
		send_request(make_request(lcdns_pkg::KIND_GOTO, 8'hFF, 3'd2, 6'd40));
		send_request(make_request(lcdns_pkg::KIND_GOTO, 8'h00, 3'd3, 6'd20));
		send_request(make_request(lcdns_pkg::KIND_GOTO, 8'hFF, 3'd4, 6'd40));
		// row zero and column zero: base wraps to row four, address drops by one
		send_request(make_request(lcdns_pkg::KIND_GOTO, 8'h00, 3'd0, 6'd0));
		// rows past four reuse the base table, column 63 lies past the display width
		send_request(make_request(lcdns_pkg::KIND_GOTO, 8'hFF, 3'd7, 6'd63));
		send_request(make_request(lcdns_pkg::KIND_GOTO, 8'h00, 3'd5, 6'd63));
		// park at the line end so the next character wraps to row two
		send_request(make_request(lcdns_pkg::KIND_GOTO, 8'h00, 3'd1, 6'd16));
		send_request(make_request(lcdns_pkg::KIND_DATA, 8'h5A, 3'd0, 6'd0));
		send_request(make_request(lcdns_pkg::KIND_DATA, 8'hA5, 3'd0, 6'd0));
		// unknown kinds must vanish without strobes or cursor change
		send_request(make_request(KIND_SPARE_LO, 8'hFF, 3'd7, 6'd63));
		send_request(make_request(KIND_SPARE_MID, 8'h00, 3'd0, 6'd0));
		send_request(make_request(KIND_SPARE_HI, 8'h81, 3'd1, 6'd1));
		send_request(make_request(lcdns_pkg::KIND_CLEAR, 8'hFF, 3'd7, 6'd63));
		send_request(make_request(lcdns_pkg::KIND_DATA, 8'h3C, 3'd0, 6'd0));
		send_request(make_request(lcdns_pkg::KIND_GOTO, 8'h00, 3'd6, 6'd0));
		send_request(make_request(lcdns_pkg::KIND_INIT, 8'hFF, 3'd7, 6'd63));

		// random part over a spread of line lengths and idling mixes
		run_phase(6'd40, 0, 0, 50);
		run_phase(6'd1, 65, 0, 50);
		// zero line length: the wrap test still looks for column one
		run_phase(6'd0, 0, 65, 50);
		// above the 40 column display width
		run_phase(6'd63, 30, 30, 50);

		// receiver holds off while the sender keeps offering requests
		drain();
		write_line_length(6'd16);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_now     = 1'b1;
		repeat (30) send_request(random_request());

		run_phase(6'($urandom_range(40, 1)), 30, 30, 40);
		drain();

		$display("covered %0d requests and %0d strobe transactions, %0d line wraps,",
			requests, strobes, wraps);
		$display("line lengths 16, 40, 1, 0, 63 and one random, plus a %0d cycle pop hold-off",
			HOLD_CYCLES);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- char_lcd_nibble_sequencer.f -----
hw/rtl/lcdns_pkg.sv
hw/rtl/lcdns_front.sv
hw/rtl/lcdns_queue.sv
hw/rtl/lcdns_back.sv
hw/rtl/char_lcd_nibble_sequencer.sv
bench/char_lcd_strobe_checker.sv
bench/char_lcd_nibble_sequencer_tb.sv
